FILE: sv/gn3_pkg.sv
// gn3_pkg: constants and a helper function for the 3D gradient noise block.
// Used by gn3_corner and gradient_noise_3d_top. No dependencies.
package gn3_pkg;

  localparam int GRADIENT_BITS_DEF   = 8;
  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int SMOOTH_FRAC         = 16;
  localparam int OUT_FRAC            = 14;
  localparam int COORD_W             = 24;
  localparam int SEED_W              = 32;
  localparam int NOISE_W             = 16;
  localparam int NUM_CORNERS         = 8;
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sd16384;

  // 13/17/5 xorshift, arithmetic right shift
  function automatic logic [31:0] mix32(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h ^ (h << 13);
    h = h ^ 32'($signed(h) >>> 17);
    h = h ^ (h << 5);
    return h;
  endfunction

endpackage

FILE: sv/gn3_corner.sv
// gn3_corner: pipelined hash and corner value for one lattice corner.
// Depends on gn3_pkg. Fully pipelined, one item per cycle.
module gn3_corner
  import gn3_pkg::*;
#(
  parameter int GRADIENT_BITS   = GRADIENT_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int VAL_W           = COORD_FRAC_BITS + GRADIENT_BITS + 4
) (
  input  logic                              clk,
  input  logic [31:0]                       seed,
  input  logic [31:0]                       cx,
  input  logic [31:0]                       cy,
  input  logic [31:0]                       cz,
  input  logic signed [COORD_FRAC_BITS:0]   ox,
  input  logic signed [COORD_FRAC_BITS:0]   oy,
  input  logic signed [COORD_FRAC_BITS:0]   oz,
  output logic signed [VAL_W-1:0]           corner_value
);
  localparam int OW = COORD_FRAC_BITS + 1;
  localparam int GW = GRADIENT_BITS + 1;
  localparam logic [GW-1:0] GBIAS = GW'(1) << (GRADIENT_BITS - 1);

  logic [31:0] h_a, h_b, h_c;
  logic [31:0] cy_a, cz_a, cz_b;
  logic [31:0] h1, h2, h3;
  logic signed [OW-1:0] ox_a, oy_a, oz_a, ox_b, oy_b, oz_b, ox_c, oy_c, oz_c;
  logic signed [OW-1:0] ox_d, oy_d, oz_d, ox_e, oy_e, oz_e;
  logic [GRADIENT_BITS-1:0] g1_d, g1_e, g2_e;
  logic signed [GW-1:0] gx, gy, gz;
  logic signed [OW+GW-1:0] px, py, pz;

  // stages 1-3: seed * cx, then * cy, then * cz, one multiply per stage
  always_ff @(posedge clk) begin
    h_a  <= seed * cx;
    cy_a <= cy;
    cz_a <= cz;
    ox_a <= ox; oy_a <= oy; oz_a <= oz;
    h_b  <= h_a * cy_a;
    cz_b <= cz_a;
    ox_b <= ox_a; oy_b <= oy_a; oz_b <= oz_a;
    h_c  <= h_b * cz_b;
    ox_c <= ox_b; oy_c <= oy_b; oz_c <= oz_b;
  end

  assign h1 = mix32(h_c);

  // stage 4: first two mixes; stage 5: third mix
  always_ff @(posedge clk) begin
    h2   <= mix32(h1);
    g1_d <= h1[GRADIENT_BITS-1:0];
    ox_d <= ox_c; oy_d <= oy_c; oz_d <= oz_c;
    h3   <= mix32(h2);
    g1_e <= g1_d;
    g2_e <= h2[GRADIENT_BITS-1:0];
    ox_e <= ox_d; oy_e <= oy_d; oz_e <= oz_d;
  end

  assign gx = $signed({1'b0, g1_e} - GBIAS);
  assign gy = $signed({1'b0, g2_e} - GBIAS);
  assign gz = $signed({1'b0, h3[GRADIENT_BITS-1:0]} - GBIAS);
  assign px = ox_e * gx;
  assign py = oy_e * gy;
  assign pz = oz_e * gz;

  // stage 6: dot product times two
  always_ff @(posedge clk) begin
    corner_value <= VAL_W'((VAL_W'(px) + VAL_W'(py) + VAL_W'(pz)) <<< 1);
  end
endmodule

FILE: sv/gradient_noise_3d_top.sv
// gradient_noise_3d_top: 3D gradient noise, one sample per cycle.
// Depends on gn3_pkg and gn3_corner.
// Pipeline: a start transfer puts done and noise_value up together, after passing the
// stages input split, six corner stages, three blends, scale and clamp.
// Throughput one item per cycle; busy is always low and the receiver cannot stall.
// Reset clears the valid pipeline and done and sets world_seed to 1.
module gradient_noise_3d_top
  import gn3_pkg::*;
#(
  parameter int GRADIENT_BITS   = GRADIENT_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  coord_x,
  input  logic signed [COORD_W-1:0]  coord_y,
  input  logic signed [COORD_W-1:0]  coord_z,
  input  logic                       cfg_we,
  input  logic signed [SEED_W-1:0]   cfg_data,
  output logic                       done,
  output logic signed [NOISE_W-1:0]  noise_value
);
  localparam int F     = COORD_FRAC_BITS;
  localparam int VAL_W = F + GRADIENT_BITS + 4;
  localparam int Q     = F + GRADIENT_BITS - 1;
  localparam int SW    = SMOOTH_FRAC + 1;
  localparam int CDLY  = 6;  // gn3_corner latency
  localparam int LAT   = CDLY + 5;

  logic [SEED_W-1:0] world_seed;
  logic [LAT-2:0] vld;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) world_seed <= 32'd1;
    else if (cfg_we) world_seed <= cfg_data;
  end

  assign busy = 1'b0;

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-3:0], start};
  end

  // stage 0: split coordinates
  logic [31:0] cell0 [3];
  logic [31:0] cell1 [3];
  logic signed [F:0] off0 [3];
  logic signed [F:0] off1 [3];
  logic [F-1:0] fr0 [3];
  logic [31:0] seed_r;
  logic signed [COORD_W-1:0] cin [3];
  assign cin[0] = coord_x;
  assign cin[1] = coord_y;
  assign cin[2] = coord_z;

  always_ff @(posedge clk) begin
    seed_r <= (world_seed == '0) ? 32'd1 : world_seed;
    for (int a = 0; a < 3; a++) begin
      cell0[a] <= 32'($signed(cin[a][COORD_W-1:F]));
      cell1[a] <= 32'($signed(cin[a][COORD_W-1:F])) + 32'd1;
      off0[a]  <= $signed({1'b0, cin[a][F-1:0]});
      off1[a]  <= $signed({1'b0, cin[a][F-1:0]}) - $signed((F+1)'(1) << F);
      fr0[a]   <= cin[a][F-1:0];
    end
  end

  // eight corner units
  logic signed [VAL_W-1:0] pv [NUM_CORNERS];
  for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_corner
    gn3_corner #(
      .GRADIENT_BITS(GRADIENT_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .VAL_W(VAL_W)
    ) u_corner (
      .clk(clk), .seed(seed_r),
      .cx(((i & 1) != 0) ? cell1[0] : cell0[0]),
      .cy((((i >> 1) & 1) != 0) ? cell1[1] : cell0[1]),
      .cz((((i >> 2) & 1) != 0) ? cell1[2] : cell0[2]),
      .ox(((i & 1) != 0) ? off1[0] : off0[0]),
      .oy((((i >> 1) & 1) != 0) ? off1[1] : off0[1]),
      .oz((((i >> 2) & 1) != 0) ? off1[2] : off0[2]),
      .corner_value(pv[i])
    );
  end

  // smoothstep, two registered stages, then delayed to line up with corners
  logic [3*F-1:0] sq [3];
  logic [F+1:0]   tw [3];
  logic [SW-1:0]  sm_p [CDLY-1][3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq[a] <= (3*F)'(fr0[a]) * (3*F)'(fr0[a]);
      tw[a] <= ((F+2)'(3) << F) - ((F+2)'(fr0[a]) << 1);
      if (3*F >= SMOOTH_FRAC)
        sm_p[0][a] <= SW'((sq[a] * (3*F)'(tw[a])) >> (3*F - SMOOTH_FRAC));
      else
        sm_p[0][a] <= SW'((SW+3*F)'(sq[a] * (3*F)'(tw[a])) << (SMOOTH_FRAC - 3*F));
      for (int k = 1; k < CDLY-1; k++) sm_p[k][a] <= sm_p[k-1][a];
    end
  end

  function automatic logic signed [VAL_W-1:0] blend(
    input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b,
    input logic [SW-1:0] s);
    logic signed [VAL_W+SW+1:0] prod;
    prod = (VAL_W+SW+2)'(b - a) * $signed({1'b0, s});
    return a + VAL_W'(prod >>> SMOOTH_FRAC);
  endfunction

  // blend x, y, z in three stages
  logic signed [VAL_W-1:0] bx [4];
  logic signed [VAL_W-1:0] by [2];
  logic signed [VAL_W-1:0] bz;
  logic [SW-1:0] sy1, sz1, sz2;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++)
      bx[k] <= blend(pv[2*k], pv[2*k+1], sm_p[CDLY-2][0]);
    sy1 <= sm_p[CDLY-2][1];
    sz1 <= sm_p[CDLY-2][2];
    by[0] <= blend(bx[0], bx[1], sy1);
    by[1] <= blend(bx[2], bx[3], sy1);
    sz2 <= sz1;
    bz <= blend(by[0], by[1], sz2);
  end

  // scale to Q1.14 with truncation toward zero, clamp
  logic signed [VAL_W+OUT_FRAC:0] r;
  always_comb begin
    if (Q >= OUT_FRAC) begin
      if (bz < 0) r = -((VAL_W+OUT_FRAC+1)'(-bz) >> (Q - OUT_FRAC));
      else        r = (VAL_W+OUT_FRAC+1)'(bz) >> (Q - OUT_FRAC);
    end else begin
      r = (VAL_W+OUT_FRAC+1)'(bz) <<< (OUT_FRAC - Q);
    end
  end

  always_ff @(posedge clk) begin
    if (r > NOISE_MAX) noise_value <= NOISE_MAX;
    else if (r < -NOISE_MAX) noise_value <= -NOISE_MAX;
    else noise_value <= NOISE_W'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld[LAT-2];
  end
endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for gradient_noise_3d_top (3D gradient noise).
// Depends on gn3_pkg and the block's RTL; predicts each noise sample in-line.
`timescale 1ns / 1ps

module tb;
  import gn3_pkg::*;

  localparam int GB = 8;
  localparam int FB = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic cfg_we = 1'b0;
  logic signed [SEED_W-1:0] cfg_data = '0;
  logic done;
  logic signed [NOISE_W-1:0] noise_value;

  point_t pending_points[$];
  logic signed [NOISE_W-1:0] expected_noise[$];
  logic [31:0] seed_model = 32'd1;
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_stretch = 1'b0;
  bit stim_done = 1'b0;

  gradient_noise_3d_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .noise_value(noise_value)
  );

  always #5 clk = ~clk;

  // xorshift 13/17/5 with arithmetic right shift
  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] h;
    h = v ^ (v << 13);
    h = h ^ ((h >> 17) | (h[31] ? 32'hFFFF8000 : 32'h0));
    h = h ^ (h << 5);
    return h;
  endfunction

  function automatic longint smoothstep(input longint f);
    longint num;
    num = f * f * (3 * (longint'(1) << FB) - 2 * f);
    return num >>> (3 * FB - 16);
  endfunction

  function automatic longint lerp16(input longint a, input longint b, input longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic logic signed [NOISE_W-1:0] noise_of(input point_t pt);
    longint c[3], fr[3], lat[3], sm[3], corner[8];
    longint ox, oy, oz, v, r;
    logic [31:0] h, h1, h2, h3, seed;
    seed = (seed_model == 0) ? 32'd1 : seed_model;
    c[0] = longint'($signed(pt.x));
    c[1] = longint'($signed(pt.y));
    c[2] = longint'($signed(pt.z));
    for (int a = 0; a < 3; a++) begin
      fr[a] = c[a] & ((longint'(1) << FB) - 1);
      lat[a] = (c[a] - fr[a]) >>> FB;
      sm[a] = smoothstep(fr[a]);
    end
    for (int i = 0; i < 8; i++) begin
      h = seed * 32'(lat[0] + (i & 1));
      h = h * 32'(lat[1] + ((i >> 1) & 1));
      h = h * 32'(lat[2] + ((i >> 2) & 1));
      h1 = xorshift(h);
      h2 = xorshift(h1);
      h3 = xorshift(h2);
      ox = (i & 1) ? fr[0] - (1 << FB) : fr[0];
      oy = ((i >> 1) & 1) ? fr[1] - (1 << FB) : fr[1];
      oz = ((i >> 2) & 1) ? fr[2] - (1 << FB) : fr[2];
      corner[i] = 2 * (ox * (longint'(h1[GB-1:0]) - (1 << (GB - 1)))
                     + oy * (longint'(h2[GB-1:0]) - (1 << (GB - 1)))
                     + oz * (longint'(h3[GB-1:0]) - (1 << (GB - 1))));
    end
    v = lerp16(lerp16(lerp16(corner[0], corner[1], sm[0]),
                      lerp16(corner[2], corner[3], sm[0]), sm[1]),
               lerp16(lerp16(corner[4], corner[5], sm[0]),
                      lerp16(corner[6], corner[7], sm[0]), sm[1]), sm[2]);
    // truncate toward zero from Q15 to Q14
    r = (v < 0) ? -((-v) >> (FB + GB - 1 - OUT_FRAC)) : (v >> (FB + GB - 1 - OUT_FRAC));
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return NOISE_W'(r);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // driver: one transfer per accepted start
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_noise.push_back(noise_of({coord_x, coord_y, coord_z}));
      end
      if ((start && !busy) || !start) begin
        if (pending_points.size() > 0 && (quiet_stretch || $urandom_range(99) >= 24)) begin
          point_t pt;
          pt = pending_points.pop_front();
          start <= 1'b1;
          coord_x <= pt.x;
          coord_y <= pt.y;
          coord_z <= pt.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_noise.size() == 0) begin
        report_mismatch("unexpected noise_value", noise_value, 0);
      end else begin
        logic signed [NOISE_W-1:0] want;
        want = expected_noise.pop_front();
        if (noise_value !== want) report_mismatch("noise_value", noise_value, want);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(4095)) - 2048);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 8'($urandom)};
      default: return COORD_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_points.size() > 0 || start || expected_noise.size() > 0)
      @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] s);
    cfg_we <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_model = s;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] seeds[6];
    seeds = '{32'd1, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, $urandom};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, cell edges, zero and wrap cases under reset seed
    pending_points.push_back('{24'h000000, 24'h000000, 24'h000000});
    pending_points.push_back('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    pending_points.push_back('{24'h800000, 24'h800000, 24'h800000});
    pending_points.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
    pending_points.push_back('{24'h000080, 24'h000080, 24'h000080});
    pending_points.push_back('{24'h0000FF, 24'h000001, 24'hFFFF00});
    pending_points.push_back('{24'h7FFF80, 24'h800080, 24'h123456});
    pending_points.push_back('{24'h555555, 24'hAAAAAA, 24'h0F0F0F});
    pending_points.push_back('{24'hAAAAAA, 24'h555555, 24'hF0F0F0});
    pending_points.push_back('{24'h000100, 24'hFFFF00, 24'h7FFF00});
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      quiet_stretch = (p == 2);
      for (int n = 0; n < 300; n++)
        pending_points.push_back('{rand_coord(), rand_coord(), rand_coord()});
      wait_drained();
    end
    stim_done = 1'b1;
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
